/* src/lr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pkg: shared definitions for the line rasteriser
// operation codes and default sizes used by the front, queue and back
// ----------------------------------------------------------------------------
package lr_pkg;

  // default coordinate width, signed
  localparam int unsigned CoordBits  = 12;
  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // kind of an input beat
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

endpackage

/* src/line_rasterizer.sv */
`timescale 1ns / 1ps
// path: an accepted beat is written into the queue, then popped into the output
//   register that drives m_axis
// throughput: one beat per cycle while m_axis is not stalled, start and advance
//   alike, set by the single add-compare error update in the back stepper
// reset: rst_ni clears the queue, the output valid flag and the line-active flag,
//   so the block comes up idle and an advance then gives an empty pixel
// ----------------------------------------------------------------------------
// line_rasterizer: bresenham line rasteriser
// start beats set up a line and give its first pixel, advance beats step it
// ----------------------------------------------------------------------------
module line_rasterizer
  import lr_pkg::*;
#(
  parameter int unsigned CoordW = CoordBits,
  localparam int unsigned InDataW  = ((4 * CoordW + 1 + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((2 * CoordW + 1 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beats
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // start_x, start_y, end_x, end_y, pen_color, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // operation
  input  logic [0:0]          s_axis_tuser,
  // result beats
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // pixel_valid
  output logic [0:0]          m_axis_tuser,
  // last_pixel
  output logic                m_axis_tlast
);

  localparam int unsigned EntryW = 4 + 5 * CoordW;

  logic [EntryW-1:0]        front_entry, queue_entry;
  logic                     q_full, q_empty, q_pop, q_push;
  logic                     pix_valid, pix_color, pix_last;
  logic signed [CoordW-1:0] pix_x, pix_y;

  // the front takes a beat whenever the queue has room
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  // set-up of a new line happens before the queue, so the back only steps
  lr_front #(
    .CoordW (CoordW)
  ) u_front (
    .op_i        (op_e'(s_axis_tuser[0])),
    .start_x_i   (s_axis_tdata[CoordW-1:0]),
    .start_y_i   (s_axis_tdata[2*CoordW-1:CoordW]),
    .end_x_i     (s_axis_tdata[3*CoordW-1:2*CoordW]),
    .end_y_i     (s_axis_tdata[4*CoordW-1:3*CoordW]),
    .pen_color_i (s_axis_tdata[4*CoordW]),
    .entry_o     (front_entry)
  );

  // decouples input stalls from output stalls
  lr_queue #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (queue_entry),
    .empty_o     (q_empty)
  );

  // line state and output register; pops one entry per cycle while the queue
  // holds one and the output register is free or being drained
  lr_back #(
    .CoordW (CoordW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (queue_entry),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_valid_o (pix_valid),
    .pixel_x_o     (pix_x),
    .pixel_y_o     (pix_y),
    .pixel_color_o (pix_color),
    .last_pixel_o  (pix_last)
  );

  // pack the result beat, pad bits tied low
  assign m_axis_tdata = OutDataW'({pix_color, pix_y, pix_x});
  assign m_axis_tuser = pix_valid;
  assign m_axis_tlast = pix_last;

endmodule

/* src/lr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_queue: short fifo between front and back
// register-based fifo of packed entries with full and empty flags
// ----------------------------------------------------------------------------
module lr_queue
  import lr_pkg::*;
#(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/lr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_front: command decode and line set-up
// classifies beats and works out steepness, ordering and deltas of a line
// ----------------------------------------------------------------------------
module lr_front
  import lr_pkg::*;
#(
  parameter int unsigned CoordW = CoordBits,
  localparam int unsigned EntryW = 4 + 5 * CoordW
) (
  input  op_e                       op_i,
  input  logic signed [CoordW-1:0]  start_x_i,
  input  logic signed [CoordW-1:0]  start_y_i,
  input  logic signed [CoordW-1:0]  end_x_i,
  input  logic signed [CoordW-1:0]  end_y_i,
  input  logic                      pen_color_i,
  output logic [EntryW-1:0]         entry_o
);

  typedef struct packed {
    op_e                       op;
    logic                      steep;
    logic                      color;
    logic                      down;
    logic signed [CoordW-1:0]  major_pos;
    logic signed [CoordW-1:0]  major_end;
    logic signed [CoordW-1:0]  minor_pos;
    logic [CoordW-1:0]         major_delta;
    logic [CoordW-1:0]         minor_delta;
  } entry_t;

  logic signed [CoordW:0]   dx, dy;
  logic [CoordW:0]          dx_abs, dy_abs;
  logic [CoordW-1:0]        dx_mag, dy_mag;
  logic                     steep;
  logic signed [CoordW-1:0] a0, a1, b0, b1;
  logic                     swap;
  entry_t                   entry;

  always_comb begin
    dx     = {end_x_i[CoordW-1], end_x_i} - {start_x_i[CoordW-1], start_x_i};
    dy     = {end_y_i[CoordW-1], end_y_i} - {start_y_i[CoordW-1], start_y_i};
    dx_abs = dx[CoordW] ? (CoordW+1)'(-dx) : dx;
    dy_abs = dy[CoordW] ? (CoordW+1)'(-dy) : dy;
    dx_mag = dx_abs[CoordW-1:0];
    dy_mag = dy_abs[CoordW-1:0];
    steep  = (dy_mag > dx_mag);

    // major axis is x, or y for a steep line
    a0 = steep ? start_y_i : start_x_i;
    a1 = steep ? end_y_i   : end_x_i;
    b0 = steep ? start_x_i : start_y_i;
    b1 = steep ? end_x_i   : end_y_i;
    swap = (a0 > a1);

    entry.op          = op_i;
    entry.steep       = steep;
    entry.color       = pen_color_i;
    entry.major_pos   = swap ? a1 : a0;
    entry.major_end   = swap ? a0 : a1;
    entry.minor_pos   = swap ? b1 : b0;
    entry.major_delta = steep ? dy_mag : dx_mag;
    entry.minor_delta = steep ? dx_mag : dy_mag;
    // step down unless the minor coordinate strictly rises
    entry.down        = swap ? !(b1 < b0) : !(b0 < b1);
  end

  assign entry_o = entry;

endmodule

/* src/lr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_back: pixel stepper
// holds the running line and emits one pixel per queued beat
// ----------------------------------------------------------------------------
module lr_back
  import lr_pkg::*;
#(
  parameter int unsigned CoordW = CoordBits,
  localparam int unsigned EntryW = 4 + 5 * CoordW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [EntryW-1:0]        entry_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     pixel_valid_o,
  output logic signed [CoordW-1:0] pixel_x_o,
  output logic signed [CoordW-1:0] pixel_y_o,
  output logic                     pixel_color_o,
  output logic                     last_pixel_o
);

  typedef struct packed {
    op_e                       op;
    logic                      steep;
    logic                      color;
    logic                      down;
    logic signed [CoordW-1:0]  major_pos;
    logic signed [CoordW-1:0]  major_end;
    logic signed [CoordW-1:0]  minor_pos;
    logic [CoordW-1:0]         major_delta;
    logic [CoordW-1:0]         minor_delta;
  } entry_t;

  entry_t entry;

  // line state
  logic                     active_q;
  logic                     steep_q, color_q, down_q;
  logic signed [CoordW-1:0] major_q, major_d;
  logic signed [CoordW-1:0] end_q;
  logic signed [CoordW-1:0] minor_q, minor_d;
  logic signed [CoordW:0]   err_q, err_d;
  logic [CoordW-1:0]        mdelta_q, ndelta_q;

  // output register
  logic                     out_valid_q;
  logic                     pix_valid_q, color_out_q, last_q;
  logic signed [CoordW-1:0] px_q, py_q;

  // selected operands
  logic                     pop, is_start, emit, last;
  logic                     c_steep, c_color, c_down;
  logic signed [CoordW-1:0] c_major, c_end, c_minor;
  logic signed [CoordW:0]   c_err, err_sub;
  logic [CoordW-1:0]        c_mdelta, c_ndelta;

  assign entry = entry_t'(entry_i);
  assign pop   = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    is_start = (entry.op == OP_START);
    emit     = pop && (is_start || active_q);

    c_steep  = is_start ? entry.steep       : steep_q;
    c_color  = is_start ? entry.color       : color_q;
    c_down   = is_start ? entry.down        : down_q;
    c_major  = is_start ? entry.major_pos   : major_q;
    c_end    = is_start ? entry.major_end   : end_q;
    c_minor  = is_start ? entry.minor_pos   : minor_q;
    c_mdelta = is_start ? entry.major_delta : mdelta_q;
    c_ndelta = is_start ? entry.minor_delta : ndelta_q;
    c_err    = is_start ? $signed({2'b00, entry.major_delta[CoordW-1:1]}) : err_q;

    last    = (c_major >= c_end);
    err_sub = c_err - $signed({1'b0, c_ndelta});
    major_d = c_major + CoordW'(1);
    minor_d = c_minor;
    err_d   = err_sub;
    if (err_sub[CoordW]) begin
      minor_d = c_down ? c_minor - CoordW'(1) : c_minor + CoordW'(1);
      err_d   = err_sub + $signed({1'b0, c_mdelta});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        active_q <= !last;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      steep_q  <= c_steep;
      color_q  <= c_color;
      down_q   <= c_down;
      end_q    <= c_end;
      mdelta_q <= c_mdelta;
      ndelta_q <= c_ndelta;
      major_q  <= major_d;
      minor_q  <= minor_d;
      err_q    <= err_d;
    end
    if (pop) begin
      pix_valid_q <= emit;
      px_q        <= emit ? (c_steep ? c_minor : c_major) : '0;
      py_q        <= emit ? (c_steep ? c_major : c_minor) : '0;
      color_out_q <= emit && c_color;
      last_q      <= emit && last;
    end
  end

  assign pop_o         = pop;
  assign out_valid_o   = out_valid_q;
  assign pixel_valid_o = pix_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = color_out_q;
  assign last_pixel_o  = last_q;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the line rasteriser
// a queue of start and advance beats feeds a falling-edge driver; every
// accepted beat runs through a bresenham predictor kept in this module, and
// a rising-edge monitor checks each pixel beat against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;
  import lr_pkg::*;

  localparam int CW    = CoordBits;
  localparam int IN_W  = ((4 * CW + 1 + 7) / 8) * 8;
  localparam int OUT_W = ((2 * CW + 1 + 7) / 8) * 8;
  localparam int CMIN  = -(1 << (CW - 1));
  localparam int CMAX  = (1 << (CW - 1)) - 1;

  // one input beat as the bench sees it
  typedef struct {
    op_e                  op;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic                 color;
  } draw_cmd_t;

  // one pixel beat, field by field
  typedef struct {
    logic                 valid;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 color;
    logic                 last;
  } pixel_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]       s_axis_tuser  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0]       m_axis_tuser;
  logic             m_axis_tlast;

  draw_cmd_t cmds_pending[$];
  pixel_t    pixels_due[$];
  int        errors   = 0;
  int        cycle_no = 0;
  logic      in_beat  = 1'b0;
  logic      calm;

  // predictor copy of the stepper state
  logic line_on   = 1'b0;
  logic steep     = 1'b0;
  int   maj_pos   = 0;
  int   maj_end   = 0;
  int   min_pos   = 0;
  int   err_acc   = 0;
  int   maj_delta = 0;
  int   min_delta = 0;
  logic step_down = 1'b0;
  logic pen       = 1'b0;

  line_rasterizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // a window with no idling on either side
  assign calm = (cycle_no >= 300) && (cycle_no < 900);

  function automatic int mag_of(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_coord(int v);
    return (v < CMIN) ? CMIN : ((v > CMAX) ? CMAX : v);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, CMAX - CMIN)) + CMIN;
  endfunction

  // bresenham step: set up on a start beat, then give the current pixel and
  // move on; an advance with no line running gives an empty pixel
  function automatic pixel_t raster_step(draw_cmd_t c);
    pixel_t r;
    int     x0, y0, x1, y1, t;
    logic   fin;
    r = '{valid: 1'b0, x: '0, y: '0, color: 1'b0, last: 1'b0};
    if (c.op == OP_START) begin
      x0 = int'(c.sx);
      y0 = int'(c.sy);
      x1 = int'(c.ex);
      y1 = int'(c.ey);
      steep = mag_of(y1 - y0) > mag_of(x1 - x0);
      if (steep) begin
        t = x0; x0 = y0; y0 = t;
        t = x1; x1 = y1; y1 = t;
      end
      // walk the major axis upwards
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      maj_pos   = x0;
      maj_end   = x1;
      min_pos   = y0;
      maj_delta = x1 - x0;
      min_delta = mag_of(y1 - y0);
      err_acc   = maj_delta / 2;
      step_down = !(y0 < y1);
      pen       = c.color;
      line_on   = 1'b1;
    end
    if (line_on) begin
      fin     = (maj_pos >= maj_end);
      r.valid = 1'b1;
      r.x     = steep ? min_pos[CW-1:0] : maj_pos[CW-1:0];
      r.y     = steep ? maj_pos[CW-1:0] : min_pos[CW-1:0];
      r.color = pen;
      r.last  = fin;
      if (fin) begin
        line_on = 1'b0;
      end else begin
        err_acc = err_acc - min_delta;
        if (err_acc < 0) begin
          min_pos = step_down ? min_pos - 1 : min_pos + 1;
          err_acc = err_acc + maj_delta;
        end
        maj_pos = maj_pos + 1;
      end
    end
    return r;
  endfunction

  // start beat followed by a number of advance beats with junk coordinates
  task automatic queue_line(int x0, int y0, int x1, int y1, logic color, int n_adv);
    draw_cmd_t c;
    c.op    = OP_START;
    c.sx    = x0[CW-1:0];
    c.sy    = y0[CW-1:0];
    c.ex    = x1[CW-1:0];
    c.ey    = y1[CW-1:0];
    c.color = color;
    cmds_pending.push_back(c);
    repeat (n_adv) begin
      c.op    = OP_ADVANCE;
      c.sx    = CW'($urandom);
      c.sy    = CW'($urandom);
      c.ex    = CW'($urandom);
      c.ey    = CW'($urandom);
      c.color = 1'($urandom);
      cmds_pending.push_back(c);
    end
  endtask

  task automatic queue_advance();
    draw_cmd_t c;
    c.op    = OP_ADVANCE;
    c.sx    = CW'($urandom);
    c.sy    = CW'($urandom);
    c.ex    = CW'($urandom);
    c.ey    = CW'($urandom);
    c.color = 1'($urandom);
    cmds_pending.push_back(c);
  endtask

  task automatic mismatch(string field, logic signed [31:0] want,
                          logic signed [31:0] got);
    errors++;
    $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  // driver: new beat on the falling edge once the last one was taken
  always @(negedge clk_i) begin : drive_beats
    draw_cmd_t  nxt;
    logic       go;
    logic [IN_W-1:0] w;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_beat) begin
        go = (cmds_pending.size() > 0) && (calm || $urandom_range(0, 99) >= 21);
        if (go) begin
          nxt = cmds_pending.pop_front();
          w = '0;
          w[CW-1:0]      = nxt.sx;
          w[2*CW-1:CW]   = nxt.sy;
          w[3*CW-1:2*CW] = nxt.ex;
          w[4*CW-1:3*CW] = nxt.ey;
          w[4*CW]        = nxt.color;
          s_axis_tdata <= w;
          s_axis_tuser <= nxt.op;
        end
        s_axis_tvalid <= go;
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  // input side: every accepted beat goes through the predictor
  always @(posedge clk_i) begin : predict_beats
    draw_cmd_t c;
    cycle_no <= cycle_no + 1;
    in_beat  <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      c.op    = op_e'(s_axis_tuser[0]);
      c.sx    = s_axis_tdata[CW-1:0];
      c.sy    = s_axis_tdata[2*CW-1:CW];
      c.ex    = s_axis_tdata[3*CW-1:2*CW];
      c.ey    = s_axis_tdata[4*CW-1:3*CW];
      c.color = s_axis_tdata[4*CW];
      pixels_due.push_back(raster_step(c));
    end
  end

  // output side: compare each pixel beat with the oldest prediction
  always @(posedge clk_i) begin : check_pixels
    pixel_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.valid = m_axis_tuser[0];
      got.x     = m_axis_tdata[CW-1:0];
      got.y     = m_axis_tdata[2*CW-1:CW];
      got.color = m_axis_tdata[2*CW];
      got.last  = m_axis_tlast;
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t ns: pixel beat with nothing due, expected none, got x %0d y %0d",
                 $time, got.x, got.y);
      end else begin
        want = pixels_due.pop_front();
        if (got.valid !== want.valid)
          mismatch("pixel_valid", 32'(want.valid), 32'(got.valid));
        if (got.x !== want.x)         mismatch("pixel_x", 32'(want.x), 32'(got.x));
        if (got.y !== want.y)         mismatch("pixel_y", 32'(want.y), 32'(got.y));
        if (got.color !== want.color)
          mismatch("pixel_color", 32'(want.color), 32'(got.color));
        if (got.last !== want.last)
          mismatch("last_pixel", 32'(want.last), 32'(got.last));
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int pick, x0, y0, x1, y1, span, n_adv;
    // advance straight out of reset, then a single-point line and an
    // advance once it is done
    queue_advance();
    queue_line(0, 0, 0, 0, 1'b1, 1);
    // corner to corner, abandoned by a restart drawn right to left
    queue_line(CMIN, CMIN, CMAX, CMAX, 1'b0, 3);
    queue_line(CMAX, CMIN, CMIN, CMAX, 1'b1, 2);
    // steep line stepping down, run past its end
    queue_line(0, 0, 2, -5, 1'b1, 6);
    // horizontal right to left, then vertical at the corner
    queue_line(3, 1, -1, 1, 1'b0, 4);
    queue_line(CMIN, CMAX, CMIN, CMAX - 2, 1'b1, 2);

    while (cmds_pending.size() < 1250) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // short line anywhere, mostly run to the end and a little past
        x0 = rand_coord();
        y0 = rand_coord();
        x1 = clamp_coord(x0 + int'($urandom_range(0, 24)) - 12);
        y1 = clamp_coord(y0 + int'($urandom_range(0, 24)) - 12);
        span = (mag_of(x1 - x0) > mag_of(y1 - y0)) ? mag_of(x1 - x0) : mag_of(y1 - y0);
        n_adv = ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, span))
                                             : span + int'($urandom_range(0, 2));
        queue_line(x0, y0, x1, y1, 1'($urandom), n_adv);
      end else if (pick < 85) begin
        // long line across the range, cut short by whatever follows
        queue_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'($urandom),
                   int'($urandom_range(0, 40)));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 3)) queue_advance();
      end else begin
        x0 = rand_coord();
        y0 = rand_coord();
        queue_line(x0, y0, x0, y0, 1'($urandom), 1);
      end
    end

    // drain: everything sent, every pixel back, then a few spare cycles
    do @(posedge clk_i);
    while (cmds_pending.size() != 0 || s_axis_tvalid || pixels_due.size() != 0);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // reset held low from the start, released on a falling edge
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // run guard
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
src/lr_pkg.sv
src/lr_queue.sv
src/lr_front.sv
src/lr_back.sv
src/line_rasterizer.sv
verif/tb_top.sv
